/* rtl/core/gcr_pkg.sv */
`timescale 1ns / 1ps
package gcr_pkg;

  localparam int AUX_NIBBLES = 86;
  localparam int AUX_AW = $clog2(AUX_NIBBLES);
  localparam logic [8:0] MAIN_END = 9'(AUX_NIBBLES + 256);
  localparam logic [7:0] FULL_TRACK_SUM = 8'd136;

  localparam logic [7:0] PRO_D5 = 8'hD5;
  localparam logic [7:0] PRO_AA = 8'hAA;
  localparam logic [7:0] PRO_ADDR = 8'h96;
  localparam logic [7:0] PRO_DATA = 8'hAD;

  localparam logic [1:0] OP_BIT = 2'd0;
  localparam logic [1:0] OP_BEGIN = 2'd1;
  localparam logic [1:0] OP_SUMMARY = 2'd2;

  localparam logic [1:0] KIND_DATA = 2'd0;
  localparam logic [1:0] KIND_SECTOR = 2'd1;
  localparam logic [1:0] KIND_FATAL = 2'd2;
  localparam logic [1:0] KIND_SUMMARY = 2'd3;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_ADDR_CKSUM = 3'd1;
  localparam logic [2:0] ST_TRACK = 3'd2;
  localparam logic [2:0] ST_BAD_NIBBLE = 3'd3;
  localparam logic [2:0] ST_DATA_CKSUM = 3'd4;
  localparam logic [2:0] ST_NO_ADDR = 3'd5;
  localparam logic [2:0] ST_MISSING = 3'd6;

  typedef enum logic [1:0] {
    REQ_NIBBLE,
    REQ_BEGIN,
    REQ_SUMMARY
  } req_kind_t;

  typedef struct packed {
    req_kind_t  kind;
    logic [7:0] nib;
  } req_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [3:0]  sector_number;
    logic [7:0]  byte_index;
    logic [7:0]  data_byte;
    logic [2:0]  status_code;
    logic [15:0] done_mask;
  } result_t;

  localparam logic [7:0] GCR_VALID [64] = '{
    8'h96, 8'h97, 8'h9A, 8'h9B, 8'h9D, 8'h9E, 8'h9F, 8'hA6,
    8'hA7, 8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hAF, 8'hB2, 8'hB3,
    8'hB4, 8'hB5, 8'hB6, 8'hB7, 8'hB9, 8'hBA, 8'hBB, 8'hBC,
    8'hBD, 8'hBE, 8'hBF, 8'hCB, 8'hCD, 8'hCE, 8'hCF, 8'hD3,
    8'hD6, 8'hD7, 8'hD9, 8'hDA, 8'hDB, 8'hDC, 8'hDD, 8'hDE,
    8'hDF, 8'hE5, 8'hE6, 8'hE7, 8'hE9, 8'hEA, 8'hEB, 8'hEC,
    8'hED, 8'hEE, 8'hEF, 8'hF2, 8'hF3, 8'hF4, 8'hF5, 8'hF6,
    8'hF7, 8'hF9, 8'hFA, 8'hFB, 8'hFC, 8'hFD, 8'hFE, 8'hFF
  };

  // physical sector of each logical sector number
  localparam logic [3:0] PHYS_OF_SEC [16] = '{
    4'd0, 4'd7, 4'd14, 4'd6, 4'd13, 4'd5, 4'd12, 4'd4,
    4'd11, 4'd3, 4'd10, 4'd2, 4'd9, 4'd1, 4'd8, 4'd15
  };

  // 6-bit value, bit 6 set for an invalid nibble
  function automatic logic [6:0] gcr_decode(input logic [7:0] nib);
    logic [6:0] res;
    logic       hit;
    res = 7'h40;
    hit = 1'b0;
    for (int k = 0; k < 64; k++) begin
      if (!hit && GCR_VALID[k] == nib) begin
        res = 7'(k);
        hit = 1'b1;
      end
    end
    return res;
  endfunction

  function automatic logic [7:0] decode44(input logic [7:0] a, input logic [7:0] b);
    return ({a[6:0], 1'b0} & 8'hAA) | (b & 8'h55);
  endfunction

endpackage

/* rtl/core/gcr_if.sv */
`timescale 1ns / 1ps
interface gcr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic       track_bit;
  modport source (output valid, output operation, output track_bit, input ready);
  modport sink (input valid, input operation, input track_bit, output ready);
endinterface

interface gcr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [3:0]  sector_number;
  logic [7:0]  byte_index;
  logic [7:0]  data_byte;
  logic [2:0]  status_code;
  logic [15:0] done_mask;
  modport source (output valid, output result_kind, output sector_number, output byte_index,
                  output data_byte, output status_code, output done_mask, input ready);
  modport sink (input valid, input result_kind, input sector_number, input byte_index,
                input data_byte, input status_code, input done_mask, output ready);
endinterface

/* rtl/core/gcr_ram.sv */
`timescale 1ns / 1ps
module gcr_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 86
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* rtl/core/gcr_front.sv */
`timescale 1ns / 1ps
module gcr_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          acc,
  input  logic [1:0]    operation,
  input  logic          track_bit,
  output logic          push,
  output gcr_pkg::req_t push_req
);
  import gcr_pkg::*;

  logic [7:0] window_r, window_nxt, shifted;

  assign shifted = {window_r[6:0], track_bit};

  always_comb begin
    window_nxt = window_r;
    push = 1'b0;
    push_req.kind = REQ_NIBBLE;
    push_req.nib = shifted;
    if (acc) begin
      case (operation)
        OP_BIT: begin
          if (shifted[7]) begin
            window_nxt = '0;
            push = 1'b1;
          end else begin
            window_nxt = shifted;
          end
        end
        OP_BEGIN: begin
          window_nxt = '0;
          push = 1'b1;
          push_req.kind = REQ_BEGIN;
        end
        OP_SUMMARY: begin
          push = 1'b1;
          push_req.kind = REQ_SUMMARY;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) window_r <= '0;
    else window_r <= window_nxt;
  end
endmodule

/* rtl/core/gcr_fifo.sv */
`timescale 1ns / 1ps
module gcr_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  gcr_pkg::req_t push_req,
  input  logic          pop,
  output logic          not_full,
  output logic          not_empty,
  output gcr_pkg::req_t head
);
  import gcr_pkg::*;

  req_t       slot_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign not_full = cnt_r != 2'd2;
  assign not_empty = cnt_r != 2'd0;
  assign head = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= push_req;
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule

/* rtl/core/gcr_back.sv */
`timescale 1ns / 1ps
module gcr_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             req_valid,
  input  gcr_pkg::req_t    req,
  output logic             pop,
  input  logic [7:0]       expected_track,
  output logic             res_valid,
  output gcr_pkg::result_t res,
  input  logic             res_ready
);
  import gcr_pkg::*;

  typedef enum logic [1:0] {
    S_ADDR_SYNC,
    S_ADDR_FIELD,
    S_DATA_SYNC,
    S_DATA_FIELD
  } stage_t;

  stage_t      stage_r, stage_nxt;
  logic [1:0]  match_r, match_nxt;
  logic [8:0]  idx_r, idx_nxt;
  logic [7:0]  addr_r [8];
  logic [5:0]  cksum_r, cksum_nxt;
  logic [3:0]  phys_r, phys_nxt, logi_r, logi_nxt;
  logic        err_r, err_nxt;
  logic [15:0] mask_r, mask_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic        seen_r, seen_nxt, halt_r, halt_nxt;
  logic [AUX_AW-1:0] ent_r, ent_nxt, ent_inc, raddr, waddr;
  logic [1:0]  grp_r, grp_nxt;
  logic        out_v_r, res_load;
  result_t     out_r, res_nxt;

  logic [7:0]  nib, sig, vol, trk, sec, ck;
  logic [6:0]  dv;
  logic        we, addr_wr;
  logic [5:0]  aux_rd, wdata;
  logic [1:0]  pair;

  assign pop = req_valid && (!out_v_r || res_ready);
  assign res_valid = out_v_r;
  assign res = out_r;
  assign nib = req.nib;
  assign dv = gcr_decode(nib);
  assign vol = decode44(addr_r[0], addr_r[1]);
  assign trk = decode44(addr_r[2], addr_r[3]);
  assign sec = decode44(addr_r[4], addr_r[5]);
  assign ck = decode44(addr_r[6], nib);
  assign ent_inc = (ent_r == AUX_AW'(AUX_NIBBLES - 1)) ? '0 : ent_r + 1'b1;
  assign pair = aux_rd[2*grp_r +: 2];
  assign waddr = idx_r[AUX_AW-1:0];

  gcr_ram #(.WIDTH(6), .DEPTH(AUX_NIBBLES)) u_aux (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(aux_rd)
  );

  always_comb begin
    stage_nxt = stage_r;
    match_nxt = match_r;
    idx_nxt = idx_r;
    cksum_nxt = cksum_r;
    phys_nxt = phys_r;
    logi_nxt = logi_r;
    err_nxt = err_r;
    mask_nxt = mask_r;
    sum_nxt = sum_r;
    seen_nxt = seen_r;
    halt_nxt = halt_r;
    ent_nxt = ent_r;
    grp_nxt = grp_r;
    raddr = ent_r;
    we = 1'b0;
    wdata = cksum_r ^ dv[5:0];
    addr_wr = 1'b0;
    res_load = 1'b0;
    res_nxt = '0;
    sig = (stage_r == S_ADDR_SYNC) ? PRO_ADDR : PRO_DATA;
    if (pop) begin
      case (req.kind)
        REQ_BEGIN: begin
          stage_nxt = S_ADDR_SYNC;
          match_nxt = '0;
          idx_nxt = '0;
          cksum_nxt = '0;
          phys_nxt = '0;
          logi_nxt = '0;
          err_nxt = 1'b0;
          mask_nxt = '0;
          sum_nxt = '0;
          seen_nxt = 1'b0;
          halt_nxt = 1'b0;
        end
        REQ_SUMMARY: begin
          res_load = 1'b1;
          res_nxt.result_kind = KIND_SUMMARY;
          res_nxt.status_code = !seen_r ? ST_NO_ADDR :
                                (sum_r != FULL_TRACK_SUM ? ST_MISSING : ST_OK);
          res_nxt.done_mask = mask_r;
        end
        REQ_NIBBLE: begin
          if (!halt_r) begin
            case (stage_r)
              S_ADDR_FIELD: begin
                addr_wr = 1'b1;
                idx_nxt = idx_r + 1'b1;
                if (idx_r[2:0] == 3'd7) begin
                  idx_nxt = '0;
                  if (ck != (vol ^ trk ^ sec) || sec[7:4] != 4'd0) begin
                    halt_nxt = 1'b1;
                    res_load = 1'b1;
                    res_nxt.result_kind = KIND_FATAL;
                    res_nxt.sector_number = sec[3:0];
                    res_nxt.status_code = ST_ADDR_CKSUM;
                    res_nxt.done_mask = mask_r;
                  end else if (trk != expected_track) begin
                    halt_nxt = 1'b1;
                    res_load = 1'b1;
                    res_nxt.result_kind = KIND_FATAL;
                    res_nxt.sector_number = sec[3:0];
                    res_nxt.status_code = ST_TRACK;
                    res_nxt.done_mask = mask_r;
                  end else begin
                    logi_nxt = sec[3:0];
                    phys_nxt = PHYS_OF_SEC[sec[3:0]];
                    stage_nxt = S_DATA_SYNC;
                    match_nxt = '0;
                  end
                end
              end
              S_DATA_FIELD: begin
                idx_nxt = idx_r + 1'b1;
                err_nxt = err_r | dv[6];
                if (idx_r < 9'(AUX_NIBBLES)) begin
                  if (!err_nxt) begin
                    cksum_nxt = cksum_r ^ dv[5:0];
                    we = 1'b1;
                  end
                end else if (idx_r < MAIN_END) begin
                  // prefetch the aux entry for the next main nibble
                  raddr = ent_inc;
                  ent_nxt = ent_inc;
                  if (ent_r == AUX_AW'(AUX_NIBBLES - 1)) grp_nxt = grp_r + 1'b1;
                  if (!err_nxt) begin
                    cksum_nxt = cksum_r ^ dv[5:0];
                    res_load = 1'b1;
                    res_nxt.result_kind = KIND_DATA;
                    res_nxt.sector_number = phys_r;
                    res_nxt.byte_index = 8'(idx_r - 9'(AUX_NIBBLES));
                    res_nxt.data_byte = {cksum_nxt, pair[0], pair[1]};
                    res_nxt.done_mask = mask_r;
                  end
                end else begin
                  res_load = 1'b1;
                  res_nxt.result_kind = KIND_SECTOR;
                  res_nxt.sector_number = phys_r;
                  if (err_nxt) res_nxt.status_code = ST_BAD_NIBBLE;
                  else if (dv[5:0] != cksum_r) res_nxt.status_code = ST_DATA_CKSUM;
                  else begin
                    res_nxt.status_code = ST_OK;
                    mask_nxt = mask_r | (16'd1 << logi_r);
                    sum_nxt = sum_r + 8'(phys_r) + 8'd1;
                  end
                  res_nxt.done_mask = mask_nxt;
                  stage_nxt = S_ADDR_SYNC;
                  match_nxt = '0;
                  idx_nxt = '0;
                  cksum_nxt = '0;
                  err_nxt = 1'b0;
                end
              end
              default: begin
                // prologue search: a mismatch drops the count, no recheck
                if (match_r == 2'd0 && nib == PRO_D5) match_nxt = 2'd1;
                else if (match_r == 2'd1 && nib == PRO_AA) match_nxt = 2'd2;
                else if (match_r == 2'd2 && nib == sig) begin
                  match_nxt = '0;
                  idx_nxt = '0;
                  if (stage_r == S_ADDR_SYNC) begin
                    stage_nxt = S_ADDR_FIELD;
                    seen_nxt = 1'b1;
                  end else begin
                    stage_nxt = S_DATA_FIELD;
                    cksum_nxt = '0;
                    err_nxt = 1'b0;
                    ent_nxt = '0;
                    grp_nxt = '0;
                    raddr = '0;
                  end
                end else match_nxt = '0;
              end
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (addr_wr) addr_r[idx_r[2:0]] <= nib;
    if (res_load) out_r <= res_nxt;
    if (!rst_n) begin
      stage_r <= S_ADDR_SYNC;
      match_r <= '0;
      idx_r <= '0;
      cksum_r <= '0;
      phys_r <= '0;
      logi_r <= '0;
      err_r <= 1'b0;
      mask_r <= '0;
      sum_r <= '0;
      seen_r <= 1'b0;
      halt_r <= 1'b0;
      ent_r <= '0;
      grp_r <= '0;
      out_v_r <= 1'b0;
    end else begin
      stage_r <= stage_nxt;
      match_r <= match_nxt;
      idx_r <= idx_nxt;
      cksum_r <= cksum_nxt;
      phys_r <= phys_nxt;
      logi_r <= logi_nxt;
      err_r <= err_nxt;
      mask_r <= mask_nxt;
      sum_r <= sum_nxt;
      seen_r <= seen_nxt;
      halt_r <= halt_nxt;
      ent_r <= ent_nxt;
      grp_r <= grp_nxt;
      if (res_load) out_v_r <= 1'b1;
      else if (res_ready) out_v_r <= 1'b0;
    end
  end
endmodule

/* rtl/core/gcr_track_bitstream_decoder.sv */
`timescale 1ns / 1ps
// GCR track decoder: one request per cycle in while the queue has room, at most one result per request out.
// A result is registered first in the queue and then in the result register, and waits longer under stall.
// Throughput: 1 request per cycle while the queue has room; a two-entry queue parts bit assembly from sector parsing.
// Reset (rst_n low, synchronous) clears all control state and expected_track; the aux
// store holds no reset value and is always written before it is read.
module gcr_track_bitstream_decoder (
  input  logic       clk,
  input  logic       rst_n,
  gcr_in_if.sink     in_ch,
  gcr_out_if.source  out_ch,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);
  import gcr_pkg::*;

  logic       acc, push, q_full_n, q_valid, pop, res_valid;
  req_t       push_req, head;
  result_t    res;
  logic [7:0] exp_track_r;

  // accept whenever the queue has room; the front never stalls otherwise
  assign in_ch.ready = q_full_n;
  assign acc = in_ch.valid && q_full_n;

  // hold the expected track number; the user must write it only while idle, the block does not enforce this
  always_ff @(posedge clk) begin
    if (!rst_n) exp_track_r <= '0;
    else if (cfg_wr_en) exp_track_r <= cfg_wr_data;
  end

  // front: shift bits, cut nibbles, classify requests
  gcr_front u_front (
    .clk(clk), .rst_n(rst_n), .acc(acc), .operation(in_ch.operation),
    .track_bit(in_ch.track_bit), .push(push), .push_req(push_req)
  );

  gcr_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .push_req(push_req), .pop(pop),
    .not_full(q_full_n), .not_empty(q_valid), .head(head)
  );

  // back: prologue search, address and data fields, result register
  gcr_back u_back (
    .clk(clk), .rst_n(rst_n), .req_valid(q_valid), .req(head), .pop(pop),
    .expected_track(exp_track_r), .res_valid(res_valid), .res(res),
    .res_ready(out_ch.ready)
  );

  assign out_ch.valid = res_valid;
  assign out_ch.result_kind = res.result_kind;
  assign out_ch.sector_number = res.sector_number;
  assign out_ch.byte_index = res.byte_index;
  assign out_ch.data_byte = res.data_byte;
  assign out_ch.status_code = res.status_code;
  assign out_ch.done_mask = res.done_mask;
endmodule
